[hdl/tea_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

  // Default number of Feistel cycles (two half-rounds each)
  localparam int CYCLES_DEFAULT = 32;

  // Round constant
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  // Operation codes
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = 8'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] block_left;
    logic [31:0] block_right;
  } tea_req_t;

  typedef struct packed {
    logic [31:0] out_left;
    logic [31:0] out_right;
  } tea_res_t;

  // Data carried between pipeline stages
  typedef struct packed {
    logic        func;
    logic [31:0] y;
    logic [31:0] z;
  } tea_stage_t;

  // TEA mixing term
  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] s,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

[hdl/tea_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher
// Pipelined TEA encrypt/decrypt of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
// A block is taken at every clock edge where start is high; busy stays low,
// so one block per clock is sustained. Each result leaves the last pipeline
// stage for one cycle, marked by done; the receiver cannot stall it. Each
// pipeline stage computes one half-round. Key words are written through the
// cfg port (always ready) and must only change while no block is in flight.
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int CYCLES = CYCLES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tea_req_t             request,
  output logic                 done,
  output tea_res_t             result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NSTAGE = 2 * CYCLES;

  logic [31:0] key_word_0;
  logic [31:0] key_word_1;
  logic [31:0] key_word_2;
  logic [31:0] key_word_3;

  logic       stg_valid [NSTAGE];
  tea_stage_t stg_data  [NSTAGE];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Write key registers; drop writes beyond the last key word
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        KEY_IDX_0: key_word_0 <= cfg_data;
        KEY_IDX_1: key_word_1 <= cfg_data;
        KEY_IDX_2: key_word_2 <= cfg_data;
        KEY_IDX_3: key_word_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // One half-round per stage
  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    localparam int CYC = g / 2;
    localparam logic [31:0] SUM_ENC = 32'(64'(TEA_DELTA) * 64'(CYC + 1));
    localparam logic [31:0] SUM_DEC = 32'(64'(TEA_DELTA) * 64'(CYCLES - CYC));

    logic        prev_valid;
    tea_stage_t  prev;
    tea_stage_t  stage_next;
    logic [31:0] sum;
    logic [31:0] mix_term;

    if (g == 0) begin : g_first
      assign prev_valid = start && !busy;
      assign prev.func  = request.func;
      assign prev.y     = request.block_left;
      assign prev.z     = request.block_right;
    end else begin : g_rest
      assign prev_valid = stg_valid[g-1];
      assign prev       = stg_data[g-1];
    end

    assign sum = (prev.func == FUNC_DECRYPT) ? SUM_DEC : SUM_ENC;

    // Select the half and its key pair by direction and stage parity
    always_comb begin
      stage_next = prev;
      if ((g % 2) == 0) begin
        if (prev.func == FUNC_ENCRYPT) begin
          mix_term     = tea_mix(prev.z, sum, key_word_0, key_word_1);
          stage_next.y = prev.y + mix_term;
        end else begin
          mix_term     = tea_mix(prev.y, sum, key_word_2, key_word_3);
          stage_next.z = prev.z - mix_term;
        end
      end else begin
        if (prev.func == FUNC_ENCRYPT) begin
          mix_term     = tea_mix(prev.y, sum, key_word_2, key_word_3);
          stage_next.z = prev.z + mix_term;
        end else begin
          mix_term     = tea_mix(prev.z, sum, key_word_0, key_word_1);
          stage_next.y = prev.y - mix_term;
        end
      end
    end

    // Advance valid with reset, payload without
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[g] <= 1'b0;
      end else begin
        stg_valid[g] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      stg_data[g] <= stage_next;
    end
  end

  assign done             = stg_valid[NSTAGE-1];
  assign result.out_left  = stg_data[NSTAGE-1].y;
  assign result.out_right = stg_data[NSTAGE-1].z;

  // Every accepted request yields done exactly after the pipeline latency
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(NSTAGE) done)
    else $error("accepted request produced no result");

  // No done without a request the latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##(NSTAGE) !done)
    else $error("result without matching request");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

[verif/tea_block_cipher_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_checker
// Watches the request, result and key-write channels of the TEA cipher.
// Each accepted request is run through a local copy of the TEA rounds under
// the current key, and the expected block is queued. Each done strobe pops
// the oldest expected block and compares both halves.
// ----------------------------------------------------------------------------
module tea_block_cipher_checker
  import tea_pkg::*;
#(
  parameter int ROUNDS = CYCLES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  tea_req_t             request,
  input  logic                 done,
  input  tea_res_t             result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending_blocks
);

  logic [31:0] key_word [4];
  tea_res_t    cipher_due_q [$];
  int          mismatches = 0;

  // One TEA half-round mixing term
  function automatic logic [31:0] round_term(input logic [31:0] half, input logic [31:0] sum,
                                             input logic [31:0] ka, input logic [31:0] kb);
    return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
  endfunction

  // Run all rounds on one block under the current key
  function automatic tea_res_t cipher_block(input tea_req_t req);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    tea_res_t    res;
    y = req.block_left;
    z = req.block_right;
    if (req.func == FUNC_ENCRYPT) begin
      sum = '0;
      for (int i = 0; i < ROUNDS; i++) begin
        sum = sum + TEA_DELTA;
        y   = y + round_term(z, sum, key_word[0], key_word[1]);
        z   = z + round_term(y, sum, key_word[2], key_word[3]);
      end
    end else begin
      sum = TEA_DELTA * 32'(ROUNDS);
      for (int i = 0; i < ROUNDS; i++) begin
        z   = z - round_term(y, sum, key_word[2], key_word[3]);
        y   = y - round_term(z, sum, key_word[0], key_word[1]);
        sum = sum - TEA_DELTA;
      end
    end
    res.out_left  = y;
    res.out_right = z;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tea_res_t due;
    if (rst) begin
      cipher_due_q.delete();
      for (int i = 0; i < 4; i++) key_word[i] = '0;
    end else begin
      // Compare a finished block against the oldest expectation
      if (done) begin
        if (cipher_due_q.size() == 0) begin
          $error("result: block %h_%h with no request in flight",
                 result.out_left, result.out_right);
          mismatches++;
        end else begin
          due = cipher_due_q.pop_front();
          if (result.out_left !== due.out_left) begin
            $error("out_left: expected %h, got %h", due.out_left, result.out_left);
            mismatches++;
          end
          if (result.out_right !== due.out_right) begin
            $error("out_right: expected %h, got %h", due.out_right, result.out_right);
            mismatches++;
          end
        end
      end
      // Queue the expected block for a new request
      if (start && !busy) cipher_due_q.push_back(cipher_block(request));
      // Track key writes; other indexes drop
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          KEY_IDX_0: key_word[0] = cfg_data;
          KEY_IDX_1: key_word[1] = cfg_data;
          KEY_IDX_2: key_word[2] = cfg_data;
          KEY_IDX_3: key_word[3] = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count     <= mismatches;
    pending_blocks <= cipher_due_q.size();
  end

endmodule

[verif/tea_block_cipher_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_test
// Drives the TEA cipher with directed and random blocks under several keys.
// Keys change only when no block is in flight; the sender inserts random
// gaps in some phases. Checking is done by tea_block_cipher_checker.
// ----------------------------------------------------------------------------
module tea_block_cipher_test;
  import tea_pkg::*;

  localparam int ROUNDS        = CYCLES_DEFAULT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_BLOCKS  = 275;
  localparam int RANDOM_PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_TOP = '1;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  tea_req_t             request;
  logic                 done;
  tea_res_t             result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int fail_count;
  int pending_blocks;
  int cycle_count     = 0;
  int sender_idle_pct = 0;

  tea_block_cipher #(.CYCLES(ROUNDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tea_block_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_blocks (pending_blocks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold one request until it is taken, then idle each following cycle at the phase rate
  task automatic send_block(input logic op, input logic [31:0] left, input logic [31:0] right);
    @(negedge clk);
    start               <= 1'b1;
    request.func        <= op;
    request.block_left  <= left;
    request.block_right <= right;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    end
  endtask

  // Drop start and wait until every block has come back
  task automatic drain_blocks();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a full key once idle, plus a write to an unused index
  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    drain_blocks();
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    write_key(CFG_IDX_W'($urandom_range(int'(KEY_IDX_TOP), int'(KEY_IDX_3) + 1)), $urandom());
  endtask

  function automatic logic [31:0] pick_half();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom();
  endfunction

  task automatic random_blocks(input int count, input int idle_pct);
    logic op;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(1) == 0) ? FUNC_ENCRYPT : FUNC_DECRYPT;
      send_block(op, pick_half(), pick_half());
    end
  endtask

  initial begin
    int idle_plan [3];
    logic [31:0] ka;
    idle_plan = '{0, 49, 13};
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes of both halves and both operations under the reset key
    send_block(FUNC_ENCRYPT, '0, '0);
    send_block(FUNC_ENCRYPT, '1, '1);
    send_block(FUNC_ENCRYPT, '0, '1);
    send_block(FUNC_ENCRYPT, '1, '0);
    send_block(FUNC_DECRYPT, '0, '0);
    send_block(FUNC_DECRYPT, '1, '1);
    send_block(FUNC_DECRYPT, '0, '1);
    send_block(FUNC_DECRYPT, '1, '0);

    // A write to an unused index must leave the key alone
    drain_blocks();
    write_key(KEY_IDX_TOP, '1);
    send_block(FUNC_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(FUNC_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);

    // All-ones key
    load_key('1, '1, '1, '1);
    send_block(FUNC_ENCRYPT, '0, '0);
    send_block(FUNC_ENCRYPT, '1, '1);
    send_block(FUNC_DECRYPT, '0, '0);
    send_block(FUNC_DECRYPT, '1, '1);

    // Alternating bit patterns, one key word at a time
    load_key(32'h5555_5555, 32'hAAAA_AAAA, '0, '1);
    send_block(FUNC_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(FUNC_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);

    // Random blocks under a fresh key per phase, rotating the gap rate
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      ka = $urandom();
      if (p == RANDOM_PHASES - 1) load_key('0, '0, '0, '0);
      else load_key(ka, $urandom(), $urandom(), $urandom());
      random_blocks(PHASE_BLOCKS, idle_plan[p % 3]);
    end

    drain_blocks();
    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
